FILE: sv/assert_macros.svh
// Assertion helpers for the lexer checks.
// Each expects clk and rst to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define LEX_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lexer check failed");

// Next-cycle implication, disabled in reset.
`define LEX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lexer check failed");

`endif

FILE: sv/lex_pkg.sv
`default_nettype none

package lex_pkg;

  // Token kinds
  localparam logic [2:0] KIND_WORD    = 3'd0;
  localparam logic [2:0] KIND_PIPE    = 3'd1;
  localparam logic [2:0] KIND_IN      = 3'd2;
  localparam logic [2:0] KIND_HEREDOC = 3'd3;
  localparam logic [2:0] KIND_OUT     = 3'd4;
  localparam logic [2:0] KIND_APPEND  = 3'd5;

  // Special bytes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SQ    = 8'h27;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // Default depth of the queue between front and back
  localparam int LEX_QDEPTH = 4;

  // Results per input byte, at most three
  localparam int LEX_MAX_RES = 3;

  typedef enum logic [6:0] {
    MODE_BETWEEN = 7'b0000001,
    MODE_WORD    = 7'b0000010,
    MODE_SQUOTE  = 7'b0000100,
    MODE_DQUOTE  = 7'b0001000,
    MODE_GT      = 7'b0010000,
    MODE_LT      = 7'b0100000,
    MODE_PIPE    = 7'b1000000
  } lex_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic [2:0] kind;
    logic       tend;
    logic       line;
    logic       err;
  } lex_res_t;

  // All results caused by one input byte; cnt is 1..3 when queued
  typedef struct packed {
    logic [1:0]                  cnt;
    lex_res_t [LEX_MAX_RES-1:0]  res;
  } lex_bundle_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic        valid;
    lex_bundle_t bundle;
  } lex_head_t;

  function automatic lex_res_t lex_mk(input logic [7:0] ch, input logic valid,
                                      input logic [2:0] kind, input logic tend,
                                      input logic line, input logic err);
    lex_res_t r;
    r.ch    = ch;
    r.valid = valid;
    r.kind  = kind;
    r.tend  = tend;
    r.line  = line;
    r.err   = err;
    return r;
  endfunction

  function automatic logic lex_is_ws(input logic [7:0] c);
    return ((c >= CH_TAB) && (c <= CH_CR)) || (c == CH_SPACE);
  endfunction

endpackage

`default_nettype wire

FILE: sv/lex_front.sv
`default_nettype none

module lex_front import lex_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  char_in,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        q_full,
  output logic             push,
  output lex_bundle_t      push_bundle
);

  lex_mode_t mode, mode_next, b_mode;
  lex_res_t  b_ent;
  logic      b_n;
  logic      use_begin;
  logic [1:0] pre_n;
  lex_res_t [LEX_MAX_RES-1:0] pre;
  logic      delim;
  logic      accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign delim    = (char_in == CH_NUL) || lex_is_ws(char_in) || (char_in == CH_PIPE) ||
                    (char_in == CH_LT) || (char_in == CH_GT);

  // Byte handled with no token open
  always_comb begin
    b_ent  = '0;
    b_n    = 1'b0;
    b_mode = MODE_BETWEEN;
    priority if (char_in == CH_NUL) begin
      b_ent = lex_mk(CH_NUL, 1'b0, KIND_WORD, 1'b0, 1'b1, 1'b0);
      b_n   = 1'b1;
    end else if (lex_is_ws(char_in)) begin
      b_n = 1'b0;
    end else if (char_in == CH_SQ) begin
      b_ent  = lex_mk(char_in, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
      b_n    = 1'b1;
      b_mode = MODE_SQUOTE;
    end else if (char_in == CH_DQ) begin
      b_ent  = lex_mk(char_in, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
      b_n    = 1'b1;
      b_mode = MODE_DQUOTE;
    end else if (char_in == CH_PIPE) begin
      b_ent  = lex_mk(char_in, 1'b1, KIND_PIPE, 1'b0, 1'b0, 1'b0);
      b_n    = 1'b1;
      b_mode = MODE_PIPE;
    end else if (char_in == CH_GT) begin
      b_mode = MODE_GT;
    end else if (char_in == CH_LT) begin
      b_mode = MODE_LT;
    end else begin
      b_ent  = lex_mk(char_in, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
      b_n    = 1'b1;
      b_mode = MODE_WORD;
    end
  end

  // Results owed by the current mode, ahead of any fresh token
  always_comb begin
    pre       = '0;
    pre_n     = 2'd0;
    use_begin = 1'b0;
    mode_next = mode;
    unique case (mode)
      MODE_WORD: begin
        if (delim) begin
          pre[0]    = lex_mk(CH_NUL, 1'b0, KIND_WORD, 1'b1, 1'b0, 1'b0);
          pre_n     = 2'd1;
          use_begin = 1'b1;
        end else begin
          pre[0] = lex_mk(char_in, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
          pre_n  = 2'd1;
        end
      end
      MODE_SQUOTE, MODE_DQUOTE: begin
        if (char_in == CH_NUL) begin
          pre[0]    = lex_mk(CH_NUL, 1'b0, KIND_WORD, 1'b0, 1'b1, 1'b1);
          pre_n     = 2'd1;
          mode_next = MODE_BETWEEN;
        end else if (char_in == ((mode == MODE_SQUOTE) ? CH_SQ : CH_DQ)) begin
          pre[0]    = lex_mk(char_in, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
          pre[1]    = lex_mk(CH_NUL, 1'b0, KIND_WORD, 1'b1, 1'b0, 1'b0);
          pre_n     = 2'd2;
          mode_next = MODE_BETWEEN;
        end else begin
          pre[0] = lex_mk(char_in, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
          pre_n  = 2'd1;
        end
      end
      MODE_GT, MODE_LT: begin
        if (char_in == ((mode == MODE_GT) ? CH_GT : CH_LT)) begin
          pre[0] = lex_mk(char_in, 1'b1, (mode == MODE_GT) ? KIND_APPEND : KIND_HEREDOC,
                          1'b0, 1'b0, 1'b0);
          pre[1] = pre[0];
          pre[2] = lex_mk(CH_NUL, 1'b0, (mode == MODE_GT) ? KIND_APPEND : KIND_HEREDOC,
                          1'b1, 1'b0, 1'b0);
          pre_n     = 2'd3;
          mode_next = MODE_BETWEEN;
        end else begin
          pre[0] = lex_mk((mode == MODE_GT) ? CH_GT : CH_LT, 1'b1,
                          (mode == MODE_GT) ? KIND_OUT : KIND_IN, 1'b0, 1'b0, 1'b0);
          pre[1] = lex_mk(CH_NUL, 1'b0, (mode == MODE_GT) ? KIND_OUT : KIND_IN,
                          1'b1, 1'b0, 1'b0);
          pre_n     = 2'd2;
          use_begin = 1'b1;
        end
      end
      MODE_PIPE: begin
        // pipe close was held back one byte
        pre[0]    = lex_mk(CH_NUL, 1'b0, KIND_PIPE, 1'b1, 1'b0, 1'b0);
        pre_n     = 2'd1;
        use_begin = 1'b1;
      end
      default: begin
        use_begin = 1'b1;
      end
    endcase
    if (use_begin) begin
      mode_next = b_mode;
    end
  end

  always_comb begin
    push_bundle.res = pre;
    push_bundle.cnt = pre_n + {1'b0, use_begin & b_n};
    for (int i = 0; i < LEX_MAX_RES; i++) begin
      if (use_begin && b_n && (pre_n == 2'(i))) begin
        push_bundle.res[i] = b_ent;
      end
    end
  end

  // Bytes that cause nothing are not queued
  assign push = accept && (push_bundle.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_BETWEEN;
    end else if (accept) begin
      mode <= mode_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lex_queue.sv
`default_nettype none

module lex_queue import lex_pkg::*; #(
  parameter int DEPTH = LEX_QDEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire lex_bundle_t push_bundle,
  input  wire logic        pop,
  output logic             full,
  output lex_head_t        head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  lex_bundle_t slots [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full        = (count == CW'(DEPTH));
  assign head.valid  = (count != '0);
  assign head.bundle = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/lex_back.sv
`default_nettype none

module lex_back import lex_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire lex_head_t   head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic [2:0]       token_kind,
  output logic             token_end,
  output logic             line_done,
  output logic             quote_error,
  output logic             last_of_run
);

  logic [1:0] idx;
  logic       emit;
  logic       last;
  lex_res_t   cur;

  assign emit = head.valid && (!out_valid || out_ready);
  assign cur  = head.bundle.res[idx];
  assign last = (idx == (head.bundle.cnt - 2'd1));
  assign pop  = emit && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
        idx       <= last ? 2'd0 : idx + 2'd1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_char    <= cur.ch;
      char_valid  <= cur.valid;
      token_kind  <= cur.kind;
      token_end   <= cur.tend;
      line_done   <= cur.line;
      quote_error <= cur.err;
      last_of_run <= last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/shell_command_lexer_top.sv
// An accepted byte is written into a queue slot; its first result then passes
// through the back-end output register. Input: one byte per cycle while queue
// space lasts. Output: one result per cycle while a bundle is queued and the
// receiver is ready. The back-end result serializer sets the sustained rate.
// Reset: synchronous, active high; clears scan mode, queue and output valid.
`default_nettype none

module shell_command_lexer_top import lex_pkg::*; #(
  parameter int QDEPTH = LEX_QDEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input byte channel
  input  wire logic [7:0]  char_in,
  input  wire logic        in_valid,
  output logic             in_ready,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_char,
  output logic             char_valid,
  output logic [2:0]       token_kind,
  output logic             token_end,
  output logic             line_done,
  output logic             quote_error,
  output logic             last_of_run
);

  // Front end: tracks scan mode, turns each byte into a bundle of 0..3
  // results. Bytes with no result (whitespace between tokens, first '<'
  // or '>') are consumed without touching the queue.
  logic        push;
  lex_bundle_t push_bundle;
  logic        q_full;

  // Queue: decouples classification from result streaming, so the front
  // keeps taking bytes while the back is still draining a multi-result item.
  lex_head_t   head;
  logic        pop;

  lex_front u_front (
    .clk         (clk),
    .rst         (rst),
    .char_in     (char_in),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .q_full      (q_full),
    .push        (push),
    .push_bundle (push_bundle)
  );

  lex_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_bundle (push_bundle),
    .pop         (pop),
    .full        (q_full),
    .head        (head)
  );

  // Back end: walks the head bundle one result per cycle, unless stalled, into
  // the output register and pops the bundle with its last result (last_of_run).
  lex_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .char_valid  (char_valid),
    .token_kind  (token_kind),
    .token_end   (token_end),
    .line_done   (line_done),
    .quote_error (quote_error),
    .last_of_run (last_of_run)
  );

endmodule

`default_nettype wire

FILE: sv/lex_checker.sv
`default_nettype none
`include "assert_macros.svh"

module lex_checker import lex_pkg::*; (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic [7:0] char_in,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_char,
  input wire logic       char_valid,
  input wire logic [2:0] token_kind,
  input wire logic       token_end,
  input wire logic       line_done,
  input wire logic       quote_error,
  input wire logic       last_of_run
);

  // a line end is a bare marker and always closes its byte's run
  `LEX_ASSERT_NOW(a_line_marker, out_valid && line_done, !char_valid && !token_end && (token_kind == KIND_WORD) && last_of_run)
  // a result is a byte or a marker, never both
  `LEX_ASSERT_NOW(a_one_role, out_valid, !(char_valid && token_end) && !(char_valid && line_done))
  // quote errors only ride on line ends
  `LEX_ASSERT_NOW(a_err_on_line, out_valid && quote_error, line_done)
  // stalled result holds
  `LEX_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(out_char) && $stable(token_kind) && $stable(last_of_run))
  // a waiting input byte holds
  `LEX_ASSERT_NEXT(a_in_hold, in_valid && !in_ready, in_valid && $stable(char_in))

endmodule

bind shell_command_lexer_top lex_checker u_lex_checker (.*);

`default_nettype wire

FILE: test/tb_shell_command_lexer_top.sv
`timescale 1ns / 1ps

// Shell lexer bench.
// Bytes of random command lines are pushed through the input channel. Each
// accepted byte is run through a behavioral copy of the token scanner, which
// queues the token beats the byte should produce. Every beat taken at the
// output is checked field by field against the oldest queued beat.
module tb_shell_command_lexer_top;
  import lex_pkg::*;

  // Idle cycles with no handshake on either side before the run is abandoned
  localparam int WATCHDOG_LIMIT = 3000;
  // Receiver hold-off used to back the block up once
  localparam int SQUEEZE_CYCLES = 80;
  // Bytes left when idling stops
  localparam int CALM_TAIL = 40;
  // Cycles after the last expected beat before closing the run
  localparam int DRAIN_CYCLES = 20;

  // One output beat, as the block presents it
  typedef struct packed {
    logic [7:0] ch;
    logic       vld;
    logic [2:0] kind;
    logic       tend;
    logic       ldone;
    logic       err;
    logic       last;
  } lex_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic [7:0] char_in = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       char_valid;
  logic [2:0] token_kind;
  logic       token_end;
  logic       line_done;
  logic       quote_error;
  logic       last_of_run;

  shell_command_lexer_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .char_in     (char_in),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .char_valid  (char_valid),
    .token_kind  (token_kind),
    .token_end   (token_end),
    .line_done   (line_done),
    .quote_error (quote_error),
    .last_of_run (last_of_run)
  );

  always #5 clk = ~clk;

  // Stimulus and scoreboard state
  logic [7:0] line_bytes[$];      // bytes still to be offered
  lex_beat_t  token_beats[$];     // beats the block still owes
  lex_mode_t  scan_state;         // scanner mode of the behavioral copy
  lex_beat_t  step_beats[3];      // beats caused by the byte being scanned
  int         step_n;
  int         total_bytes = 0;
  int         bytes_taken = 0;
  int         mismatches = 0;
  logic       in_took = 1'b0;
  logic       calm;

  // Idling stops near the end so the tail runs at full rate
  assign calm = (bytes_taken + CALM_TAIL >= total_bytes);

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Behavioral scanner
  // ---------------------------------------------------------------------
  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic void emit(input logic [7:0] ch, input logic vld,
                               input logic [2:0] kind, input logic tend,
                               input logic ldone, input logic err);
    step_beats[step_n] = '{ch, vld, kind, tend, ldone, err, 1'b0};
    step_n++;
  endfunction

  // Byte seen with no token open
  function automatic void open_token(input logic [7:0] c);
    scan_state = MODE_BETWEEN;
    if (c == CH_NUL) begin
      emit(8'h00, 1'b0, KIND_WORD, 1'b0, 1'b1, 1'b0);
    end else if (is_blank(c)) begin
      // skipped
    end else if (c == CH_SQ || c == CH_DQ) begin
      emit(c, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
      scan_state = (c == CH_SQ) ? MODE_SQUOTE : MODE_DQUOTE;
    end else if (c == CH_PIPE) begin
      emit(c, 1'b1, KIND_PIPE, 1'b0, 1'b0, 1'b0);
      scan_state = MODE_PIPE;
    end else if (c == CH_GT) begin
      scan_state = MODE_GT;
    end else if (c == CH_LT) begin
      scan_state = MODE_LT;
    end else begin
      emit(c, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
      scan_state = MODE_WORD;
    end
  endfunction

  // Scan one accepted byte and queue the beats it causes
  function automatic void scan_byte(input logic [7:0] c);
    logic [7:0] quote;
    logic [7:0] op;
    logic [2:0] one_kind;
    logic [2:0] two_kind;
    lex_beat_t  b;
    step_n = 0;
    case (scan_state)
      MODE_WORD: begin
        if (c == CH_NUL || is_blank(c) || c == CH_PIPE || c == CH_LT || c == CH_GT) begin
          // delimiter closes the word, then is scanned as a byte with no token open
          emit(8'h00, 1'b0, KIND_WORD, 1'b1, 1'b0, 1'b0);
          open_token(c);
        end else begin
          emit(c, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
        end
      end
      MODE_SQUOTE, MODE_DQUOTE: begin
        quote = (scan_state == MODE_SQUOTE) ? CH_SQ : CH_DQ;
        if (c == CH_NUL) begin
          // line ended inside the quote: no token close, error flag
          emit(8'h00, 1'b0, KIND_WORD, 1'b0, 1'b1, 1'b1);
          scan_state = MODE_BETWEEN;
        end else if (c == quote) begin
          emit(c, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
          emit(8'h00, 1'b0, KIND_WORD, 1'b1, 1'b0, 1'b0);
          scan_state = MODE_BETWEEN;
        end else begin
          emit(c, 1'b1, KIND_WORD, 1'b0, 1'b0, 1'b0);
        end
      end
      MODE_GT, MODE_LT: begin
        op       = (scan_state == MODE_GT) ? CH_GT : CH_LT;
        one_kind = (scan_state == MODE_GT) ? KIND_OUT : KIND_IN;
        two_kind = (scan_state == MODE_GT) ? KIND_APPEND : KIND_HEREDOC;
        if (c == op) begin
          emit(op, 1'b1, two_kind, 1'b0, 1'b0, 1'b0);
          emit(op, 1'b1, two_kind, 1'b0, 1'b0, 1'b0);
          emit(8'h00, 1'b0, two_kind, 1'b1, 1'b0, 1'b0);
          scan_state = MODE_BETWEEN;
        end else begin
          emit(op, 1'b1, one_kind, 1'b0, 1'b0, 1'b0);
          emit(8'h00, 1'b0, one_kind, 1'b1, 1'b0, 1'b0);
          open_token(c);
        end
      end
      MODE_PIPE: begin
        // the pipe's close was held back to this byte
        emit(8'h00, 1'b0, KIND_PIPE, 1'b1, 1'b0, 1'b0);
        open_token(c);
      end
      default: open_token(c);
    endcase
    for (int i = 0; i < step_n; i++) begin
      b = step_beats[i];
      b.last = (i == step_n - 1);
      token_beats.push_back(b);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Output check
  // ---------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  task automatic check_beat();
    lex_beat_t want;
    if (token_beats.size() == 0) begin
      report_mismatch($sformatf("unexpected beat char %0h", out_char));
    end else begin
      want = token_beats.pop_front();
      check_field("out_char", out_char, want.ch);
      check_field("char_valid", 8'(char_valid), 8'(want.vld));
      check_field("token_kind", 8'(token_kind), 8'(want.kind));
      check_field("token_end", 8'(token_end), 8'(want.tend));
      check_field("line_done", 8'(line_done), 8'(want.ldone));
      check_field("quote_error", 8'(quote_error), 8'(want.err));
      check_field("last_of_run", 8'(last_of_run), 8'(want.last));
    end
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
      scan_state = MODE_BETWEEN;
    end else begin
      in_took <= in_valid && in_ready;
      if (out_valid && out_ready)
        check_beat();
      if (in_valid && in_ready) begin
        scan_byte(char_in);
        bytes_taken <= bytes_taken + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Byte sender: holds each byte until taken, idles in random bursts
  // ---------------------------------------------------------------------
  int send_gap = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // byte still waiting, keep it steady
    end else if (send_gap != 0) begin
      send_gap <= send_gap - 1;
      in_valid <= 1'b0;
    end else if (line_bytes.size() == 0) begin
      in_valid <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      send_gap <= $urandom_range(0, 11);
      in_valid <= 1'b0;
    end else begin
      char_in  <= line_bytes.pop_front();
      in_valid <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Beat receiver: random stall bursts, plus one long hold-off partway in
  // so the internal queue fills and in_ready drops
  // ---------------------------------------------------------------------
  int   sink_gap = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (!hold_done && bytes_taken >= 100) begin
      hold_done <= 1'b1;
      hold_left <= SQUEEZE_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (sink_gap != 0) begin
      sink_gap  <= sink_gap - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      sink_gap  <= $urandom_range(0, 11);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Watchdog: too long with no handshake anywhere
  // ---------------------------------------------------------------------
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("** shell_command_lexer_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Line generation
  // ---------------------------------------------------------------------
  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      line_bytes.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    do
      b = 8'($urandom_range(1, 255));
    while (is_blank(b) || b == CH_PIPE || b == CH_LT || b == CH_GT ||
           b == CH_SQ || b == CH_DQ);
    return b;
  endfunction

  function automatic logic [7:0] blank_byte();
    int pick;
    pick = $urandom_range(9, 14);
    return (pick == 14) ? CH_SPACE : 8'(pick);
  endfunction

  // Mostly well-formed lines of words, quotes and operators; some raw noise
  task automatic add_line();
    int         pieces;
    int         len;
    int         pick;
    logic [7:0] quote;
    logic [7:0] b;
    if ($urandom_range(0, 5) == 0) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++)
        line_bytes.push_back(8'($urandom_range(0, 255)));
      line_bytes.push_back(CH_NUL);
      return;
    end
    pieces = $urandom_range(0, 6);
    for (int p = 0; p < pieces; p++) begin
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        len = $urandom_range(1, 5);
        line_bytes.push_back(word_byte());
        for (int i = 1; i < len; i++) begin
          // an inner quote is just a word byte
          if ($urandom_range(0, 7) == 0)
            line_bytes.push_back($urandom_range(0, 1) ? CH_SQ : CH_DQ);
          else
            line_bytes.push_back(word_byte());
        end
      end else if (pick == 4) begin
        quote = $urandom_range(0, 1) ? CH_SQ : CH_DQ;
        line_bytes.push_back(quote);
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) begin
          do
            b = 8'($urandom_range(1, 255));
          while (b == quote);
          line_bytes.push_back(b);
        end
        if ($urandom_range(0, 5) == 0) begin
          // leave the quote open to the end of the line
          line_bytes.push_back(CH_NUL);
          return;
        end
        line_bytes.push_back(quote);
      end else if (pick == 5) begin
        line_bytes.push_back(CH_PIPE);
      end else if (pick == 6 || pick == 7) begin
        line_bytes.push_back(CH_LT);
        if (pick == 7)
          line_bytes.push_back(CH_LT);
      end else begin
        line_bytes.push_back(CH_GT);
        if (pick == 9)
          line_bytes.push_back(CH_GT);
      end
      // separator: none, or a short run of blanks
      if ($urandom_range(0, 2) != 0) begin
        len = $urandom_range(1, 2);
        for (int i = 0; i < len; i++)
          line_bytes.push_back(blank_byte());
      end
    end
    line_bytes.push_back(CH_NUL);
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    // Directed lines:
    //   quote byte inside a word, word closed by a pipe, pipe's late close,
    //   >> then lone < followed by byte FF, quote with the other quote in it,
    //   unclosed double quote, << and a pending > at line end,
    //   blank-only line at the whitespace range edges.
    add_text("a'|>><\377 'x\"' \"y");
    line_bytes.push_back(CH_NUL);
    add_text("<<>");
    line_bytes.push_back(CH_NUL);
    add_text("\011\015");
    line_bytes.push_back(CH_NUL);
    while (line_bytes.size() < 260)
      add_line();
    total_bytes = line_bytes.size();

    repeat (6) @(negedge clk);
    rst = 1'b0;

    // every byte taken and every owed beat seen
    while (bytes_taken != total_bytes || token_beats.size() != 0)
      @(negedge clk);
    // let any stray beat show up
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (token_beats.size() != 0)
      report_mismatch($sformatf("%0d beats never came", token_beats.size()));

    if (mismatches == 0)
      $display("** shell_command_lexer_top: PASSED **");
    else
      $display("** shell_command_lexer_top: FAILED **");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+sv
sv/lex_pkg.sv
sv/lex_front.sv
sv/lex_queue.sv
sv/lex_back.sv
sv/shell_command_lexer_top.sv
sv/lex_checker.sv
test/tb_shell_command_lexer_top.sv
